[design/pip_pkg.sv]
// Package for the point-in-polygon block: shared constants, types and codes.
// Used by pip_edge, pip_seq and the top level; no dependencies.
package pip_pkg;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;
  localparam int FIELD_BITS       = 16;
  localparam int COUNT_BITS       = 7;
  localparam int MARGIN_BITS      = 15;
  localparam int MIN_POLY         = 3;
  localparam int TDATA_BITS       = 40;
  localparam int TUSER_OUT_BITS   = 2;

  typedef enum logic {ACT_WRITE = 1'b0, ACT_TEST = 1'b1} action_t;
  typedef enum logic {REG_VERTEX_COUNT = 1'b0, REG_EDGE_MARGIN = 1'b1} reg_index_t;

  // Per-edge verdict passed from the edge unit to the sequencer.
  typedef struct packed {
    logic near;
    logic crossing;
  } edge_flags_t;
endpackage

[design/pip_ram.sv]
// Generic single-port-write, single-read RAM with a registered read.
// Depends on nothing.
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/pip_edge.sv]
// Edge unit: four-stage pipeline that tests one edge against the point.
// Depends on pip_pkg. The stage 3 multipliers are 2*PW bits wide (70 for CB = 16).
module pip_edge #(
  parameter int CB = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [CB-1:0]     px,
  input  logic signed [CB-1:0]     py,
  input  logic signed [CB-1:0]     ax,
  input  logic signed [CB-1:0]     ay,
  input  logic signed [CB-1:0]     bx,
  input  logic signed [CB-1:0]     by,
  input  logic [pip_pkg::MARGIN_BITS-1:0] margin,
  output logic                     out_valid,
  output pip_pkg::edge_flags_t     flags
);
  localparam int DW = CB + 1;      // differences
  localparam int PW = 2 * DW + 1;  // products and sums of two
  localparam int MW = 2 * pip_pkg::MARGIN_BITS;
  localparam int WW = 2 * PW;      // cross squared, m2 * len2

  // Stage 1: differences.
  logic               v1;
  logic signed [DW-1:0] abx, aby, apx, apy, bpx, bpy;
  logic               str1; // ray test: a is vertex i, b is vertex j
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    abx <= DW'(bx) - DW'(ax);
    aby <= DW'(by) - DW'(ay);
    apx <= DW'(px) - DW'(ax);
    apy <= DW'(py) - DW'(ay);
    bpx <= DW'(px) - DW'(bx);
    bpy <= DW'(py) - DW'(by);
    str1 <= (ay > py) != (by > py);
  end

  // Stage 2: products.
  logic v2, str2;
  logic signed [PW-1:0] len2, dot, da2, db2, cr, lhs, rhs;
  logic signed [DW-1:0] den2;
  logic [MW-1:0] m2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    len2 <= PW'(abx * abx) + PW'(aby * aby);
    dot  <= PW'(apx * abx) + PW'(apy * aby);
    da2  <= PW'(apx * apx) + PW'(apy * apy);
    db2  <= PW'(bpx * bpx) + PW'(bpy * bpy);
    cr   <= PW'(abx * apy) - PW'(aby * apx);
    // ray: lhs = (px-xi)*(yj-yi), rhs = (xj-xi)*(py-yi)
    lhs  <= PW'(apx * aby);
    rhs  <= PW'(abx * apy);
    den2 <= aby;
    str2 <= str1;
    m2   <= MW'(margin) * MW'(margin);
  end

  // Stage 3: wide products and ray verdict.
  logic v3, near_end3, mid3, cross3, en3;
  logic [WW-1:0] cr2, ml;
  logic [PW-1:0] ucr;
  always_comb ucr = cr[PW-1] ? PW'(-cr) : PW'(cr);
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    en3 <= margin != '0;
    cr2 <= WW'(ucr) * WW'(ucr);
    ml  <= WW'(m2) * WW'(len2);
    if (len2 == '0 || dot[PW-1] || dot == '0) begin
      mid3 <= 1'b0;
      near_end3 <= {1'b0, da2} <= (PW + 1)'(m2);
    end else if (dot >= len2) begin
      mid3 <= 1'b0;
      near_end3 <= {1'b0, db2} <= (PW + 1)'(m2);
    end else begin
      mid3 <= 1'b1;
      near_end3 <= 1'b0;
    end
    // A straddling edge never has a zero height, so the sign bit alone
    // tells the direction.
    cross3 <= str2 && (!den2[DW-1] ? (lhs < rhs) : (lhs > rhs));
  end

  // Stage 4: verdict.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v3;
    flags.near     <= en3 && (mid3 ? (cr2 <= ml) : near_end3);
    flags.crossing <= cross3;
  end
endmodule

[design/pip_seq.sv]
// Sequencer: stores vertices in two RAMs, streams edges through the edge unit.
// Depends on pip_pkg, pip_ram and pip_edge.
module pip_seq #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [5:0]                      in_index,
  input  logic [pip_pkg::FIELD_BITS-1:0]  in_x,
  input  logic [pip_pkg::FIELD_BITS-1:0]  in_y,
  input  logic [pip_pkg::COUNT_BITS-1:0]  vcount,
  input  logic [pip_pkg::MARGIN_BITS-1:0] margin,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [1:0]                      res_data
);
  localparam int UB = COORD_BITS < pip_pkg::FIELD_BITS ? COORD_BITS : pip_pkg::FIELD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = AW + 1;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_t;
  state_t state;

  logic signed [UB-1:0] px, py, bx, by, rx, ry;
  logic [NW-1:0] n, issue, recv;
  logic [AW-1:0] raddr;
  logic          rd_v, rd_first, e_valid, e_out_v;
  logic          near_acc, inside_acc;
  pip_pkg::edge_flags_t fl;
  logic          wr;

  assign in_ready = state == S_IDLE && !res_valid;
  assign wr = in_valid && in_ready && in_action == pip_pkg::ACT_WRITE
              && 32'(in_index) < 32'(MAX_VERTICES);

  pip_ram #(.WIDTH(UB), .DEPTH(MAX_VERTICES)) u_ram_x (
    .clk, .we(wr), .waddr(AW'(in_index)), .wdata(in_x[UB-1:0]),
    .raddr(raddr), .rdata(rx));
  pip_ram #(.WIDTH(UB), .DEPTH(MAX_VERTICES)) u_ram_y (
    .clk, .we(wr), .waddr(AW'(in_index)), .wdata(in_y[UB-1:0]),
    .raddr(raddr), .rdata(ry));

  // Read order: n-1, 0, 1, ..., n-1. Edge k pairs vertex k-1 with vertex k;
  // its margin test uses a=k-1, b=k and its ray test the same pair.
  always_comb begin
    raddr = issue == '0 ? AW'(n - 1'b1) : AW'(issue - 1'b1);
  end

  assign e_valid = rd_v && !rd_first;

  pip_edge #(.CB(UB)) u_edge (
    .clk, .rst, .in_valid(e_valid), .px, .py, .ax(bx), .ay(by), .bx(rx), .by(ry),
    .margin, .out_valid(e_out_v), .flags(fl));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= state == S_RUN;
      rd_first <= issue == '0;
      if (rd_v) begin
        bx <= rx;
        by <= ry;
      end
      if (e_out_v) begin
        recv <= recv + 1'b1;
        near_acc <= near_acc | fl.near;
        inside_acc <= inside_acc ^ fl.crossing;
      end
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready && in_action == pip_pkg::ACT_TEST) begin
            px <= in_x[UB-1:0];
            py <= in_y[UB-1:0];
            n <= 32'(vcount) > 32'(MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount);
            issue <= '0;
            recv <= '0;
            near_acc <= 1'b0;
            inside_acc <= 1'b0;
            if (vcount < 7'(pip_pkg::MIN_POLY)) begin
              res_data <= 2'b00;
              res_valid <= 1'b1;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          issue <= issue + 1'b1;
          if (issue == n) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (recv == n) state <= S_OUT;
        end
        S_OUT: begin
          res_data <= {near_acc, inside_acc && !near_acc};
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[design/point_in_polygon_with_edge_margin_top.sv]
// Top level of the point-in-polygon block with edge margin.
// Depends on pip_pkg and pip_seq.
//
// Usage: configuration writes on cfg_* set vertex_count (index 0) and
// edge_margin (index 1); write only while idle. Input beats on s_axis carry
// action, vertex_index, coord_x and coord_y. A write beat stores one vertex
// and gives no result. A test beat gives one result beat on
// m_axis: tuser bit 0 inside_res, bit 1 near_edge.
// A test streams the vertices through the single read port of the vertex
// memories (one vertex per cycle) and its edges through the four-stage edge
// pipeline; with fewer than three vertices the result follows in the next cycle.
// Reset clears the control and configuration registers; vertex memories hold
// no reset value and every vertex must be written before a test reads it. While
// a result waits on m_axis_tready, no new input beat is accepted.
module point_in_polygon_with_edge_margin_top #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // vertex_index[5:0], coord_x[21:6], coord_y[37:22]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // inside_res[0], zero fill
  output logic [1:0]  m_axis_tuser,  // inside_res[0], near_edge[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [pip_pkg::COUNT_BITS-1:0]  vcount;
  logic [pip_pkg::MARGIN_BITS-1:0] margin;
  logic [1:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= '0;
      margin <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pip_pkg::REG_VERTEX_COUNT: vcount <= cfg_data[pip_pkg::COUNT_BITS-1:0];
        pip_pkg::REG_EDGE_MARGIN:  margin <= cfg_data[pip_pkg::MARGIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  pip_seq #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_seq (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_action(s_axis_tuser), .in_index(s_axis_tdata[5:0]),
    .in_x(s_axis_tdata[21:6]), .in_y(s_axis_tdata[37:22]),
    .vcount, .margin,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res));

  assign m_axis_tuser = res;
  assign m_axis_tdata = {7'b0, res[0]};

  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("inside and near_edge both set");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input accepted while result pending");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'b0)
    else $error("tdata fill not zero");
endmodule

[tb/tb_point_in_polygon_with_edge_margin_top.sv]
// Self-checking testbench for point_in_polygon_with_edge_margin_top.
// Depends on pip_pkg and the block's RTL; a built-in predictor checks each
// result beat against polygons, margins and points driven from here.
`timescale 1ns / 1ps

module tb_point_in_polygon_with_edge_margin_top;

  localparam int NVERT = pip_pkg::MAX_VERTICES_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  point_in_polygon_with_edge_margin_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the polygon and registers.
  longint      poly_x [NVERT];
  longint      poly_y [NVERT];
  int          poly_count = 0;
  longint      margin_q = 0;
  // Expected {near_edge, inside_res} per test beat, oldest first.
  bit [1:0]    verdict_q [$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off = 0;
  longint      cycles = 0;
  int          mismatches = 0;
  int          writes_sent = 0;
  int          tests_sent = 0;
  int          results_seen = 0;
  int          near_seen = 0;
  int          inside_seen = 0;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit edge_is_near(longint px, longint py, longint ax, longint ay,
                                      longint bx, longint by, longint m2);
    longint abx, aby, apx, apy, bpx, bpy, len2, dot, cr;
    logic [127:0] cr2, lim;
    abx = bx - ax; aby = by - ay;
    apx = px - ax; apy = py - ay;
    len2 = abx * abx + aby * aby;
    dot = apx * abx + apy * aby;
    if (len2 == 0 || dot <= 0) return (apx * apx + apy * apy) <= m2;
    if (dot >= len2) begin
      bpx = px - bx; bpy = py - by;
      return (bpx * bpx + bpy * bpy) <= m2;
    end
    // Interior projection: distance squared is cross squared over length squared.
    cr = abx * apy - aby * apx;
    if (cr < 0) cr = -cr;
    cr2 = 128'(cr) * 128'(cr);
    lim = 128'(m2) * 128'(len2);
    return cr2 <= lim;
  endfunction

  function automatic bit ray_hits(longint px, longint py, longint xi, longint yi,
                                  longint xj, longint yj);
    longint den, lhs, rhs;
    if ((yi > py) == (yj > py)) return 1'b0;
    den = yj - yi;
    lhs = (px - xi) * den;
    rhs = (xj - xi) * (py - yi);
    return (den > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic bit [1:0] classify_point(longint px, longint py);
    int n, k, j;
    bit in_poly;
    n = (poly_count > NVERT) ? NVERT : poly_count;
    if (n < pip_pkg::MIN_POLY) return 2'b00;
    if (margin_q > 0) begin
      for (int i = 0; i < n; i++) begin
        k = (i + 1 == n) ? 0 : i + 1;
        if (edge_is_near(px, py, poly_x[i], poly_y[i], poly_x[k], poly_y[k],
                         margin_q * margin_q))
          return 2'b10;
      end
    end
    in_poly = 1'b0;
    for (int i = 0; i < n; i++) begin
      j = (i == 0) ? n - 1 : i - 1;
      if (ray_hits(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j])) in_poly = ~in_poly;
    end
    return {1'b0, in_poly};
  endfunction

  // Result side: random stalls, long hold-offs and the compare.
  always @(posedge clk) begin
    bit [1:0] want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, verdict_q.size());
      $display("tb_point_in_polygon_with_edge_margin_top: errors");
      $finish;
    end else begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with nothing expected: tuser=%b",
                                         m_axis_tuser);
        end else begin
          want = verdict_q.pop_front();
          near_seen += want[1];
          inside_seen += want[0];
          if (m_axis_tuser[0] !== want[0] || m_axis_tuser[1] !== want[1] ||
              m_axis_tdata !== {7'b0, want[0]}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: inside %b/%b near %b/%b tdata %h (exp/got)",
                       want[0], m_axis_tuser[0], want[1], m_axis_tuser[1], m_axis_tdata);
          end
        end
      end
    end
  end

  task automatic send_beat(pip_pkg::action_t act, int slot, int x, int y);
    logic [15:0] cx, cy;
    cx = 16'(clamp16(x));
    cy = 16'(clamp16(y));
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {2'b00, cy, cx, 6'(slot)};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (act == pip_pkg::ACT_WRITE) begin
      poly_x[slot] = longint'($signed(cx));
      poly_y[slot] = longint'($signed(cy));
      writes_sent++;
    end else begin
      verdict_q.push_back(classify_point($signed(cx), $signed(cy)));
      tests_sent++;
    end
  endtask

  task automatic wait_results;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Drain the block, then let any trailing vertex write finish.
  task automatic settle;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(pip_pkg::reg_index_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == pip_pkg::REG_VERTEX_COUNT) poly_count = value & 8'h7F;
    else margin_q = value & 16'h7FFF;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_polygon(int count, int margin);
    settle();
    write_reg(pip_pkg::REG_VERTEX_COUNT, count);
    write_reg(pip_pkg::REG_EDGE_MARGIN, margin);
  endtask

  // Every slot is written up front so no test ever reads an empty slot.
  task automatic test_fill_vertices;
    send_beat(pip_pkg::ACT_WRITE, 0, -32768, -32768);
    send_beat(pip_pkg::ACT_WRITE, 1, 32767, -32768);
    send_beat(pip_pkg::ACT_WRITE, 2, 32767, 32767);
    send_beat(pip_pkg::ACT_WRITE, 3, -32768, 32767);
    for (int i = 4; i < NVERT; i++)
      send_beat(pip_pkg::ACT_WRITE, i, $signed(16'($urandom)), $signed(16'($urandom)));
  endtask

  task automatic test_directed_cases;
    set_polygon(0, 0);
    send_beat(pip_pkg::ACT_TEST, 0, 0, 0);
    set_polygon(2, 100);
    send_beat(pip_pkg::ACT_TEST, 63, 32767, -32768);
    // Full square, no margin: center, min corner, left edge in; max corner, right edge out.
    set_polygon(4, 0);
    send_beat(pip_pkg::ACT_TEST, 0, 0, 0);
    send_beat(pip_pkg::ACT_TEST, 0, -32768, -32768);
    send_beat(pip_pkg::ACT_TEST, 0, 32767, 32767);
    send_beat(pip_pkg::ACT_TEST, 0, 32767, 0);
    send_beat(pip_pkg::ACT_TEST, 0, -32768, 0);
    set_polygon(4, 32767);
    send_beat(pip_pkg::ACT_TEST, 0, 0, 0);
    send_beat(pip_pkg::ACT_TEST, 0, 1, -1);
    // A repeated vertex makes a zero-length edge.
    settle();
    send_beat(pip_pkg::ACT_WRITE, 4, -32768, 32767);
    set_polygon(5, 16);
    send_beat(pip_pkg::ACT_TEST, 0, -32760, 32760);
    send_beat(pip_pkg::ACT_TEST, 0, -32700, 32700);
    send_beat(pip_pkg::ACT_TEST, 0, 0, -32768);
    send_beat(pip_pkg::ACT_TEST, 0, 100, 200);
    // Counts past the store size saturate to the full store.
    set_polygon(127, 1);
    send_beat(pip_pkg::ACT_TEST, 0, 0, 0);
    send_beat(pip_pkg::ACT_TEST, 0, 12345, -2222);
    set_polygon(64, 0);
    send_beat(pip_pkg::ACT_TEST, 0, -5, 7);
  endtask

  task automatic test_random_polygons(int send_pct, int recv_pct, int quota);
    int done, count, nv, span, ox, oy, r, margin, npts, kind, a, b, t, jit, px, py;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < quota) begin
      r = $urandom_range(99);
      if (r < 8) count = $urandom_range(2);
      else if (r < 16) count = $urandom_range(127, 64);
      else if (r < 26) count = $urandom_range(63, 13);
      else count = $urandom_range(12, 3);
      nv = (count > NVERT) ? NVERT : count;
      case ($urandom_range(4))
        0: span = 8;
        1: span = 200;
        2: span = 3000;
        3: span = 16000;
        default: span = 32767;
      endcase
      ox = (span == 32767) ? 0 : int'($urandom_range(65535 - 2 * span)) - 32768 + span;
      oy = (span == 32767) ? 0 : int'($urandom_range(65535 - 2 * span)) - 32768 + span;
      settle();
      for (int i = 0; i < nv; i++) begin
        if (i > 0 && $urandom_range(9) == 0)
          send_beat(pip_pkg::ACT_WRITE, i, int'(poly_x[i-1]), int'(poly_y[i-1]));
        else
          send_beat(pip_pkg::ACT_WRITE, i, ox + $urandom_range(2 * span) - span,
                    oy + $urandom_range(2 * span) - span);
        done++;
      end
      r = $urandom_range(99);
      if (r < 25) margin = 0;
      else if (r < 75) margin = $urandom_range(span / 8 + 1, 1);
      else if (r < 90) margin = $urandom_range(32767);
      else margin = 32767;
      set_polygon(count, margin);
      npts = $urandom_range(30, 15);
      for (int p = 0; p < npts; p++) begin
        if (nv > 0 && $urandom_range(19) == 0) begin
          a = $urandom_range(nv - 1);
          send_beat(pip_pkg::ACT_WRITE, a, ox + $urandom_range(2 * span) - span,
                    oy + $urandom_range(2 * span) - span);
        end else begin
          kind = (nv < 2) ? 0 : $urandom_range(5);
          jit = margin + 2;
          a = (nv < 2) ? 0 : $urandom_range(nv - 1);
          b = (a + 1 == nv) ? 0 : a + 1;
          case (kind)
            0: begin
              px = $signed(16'($urandom));
              py = $signed(16'($urandom));
            end
            1, 2: begin
              px = ox + $urandom_range(3 * span) - 3 * span / 2;
              py = oy + $urandom_range(3 * span) - 3 * span / 2;
            end
            3: begin
              px = int'(poly_x[a]) + $urandom_range(2 * jit) - jit;
              py = int'(poly_y[a]) + $urandom_range(2 * jit) - jit;
            end
            default: begin
              t = $urandom_range(16);
              px = int'(poly_x[a] + (poly_x[b] - poly_x[a]) * t / 16)
                   + $urandom_range(2 * jit) - jit;
              py = int'(poly_y[a] + (poly_y[b] - poly_y[a]) * t / 16)
                   + $urandom_range(2 * jit) - jit;
            end
          endcase
          send_beat(pip_pkg::ACT_TEST, $urandom_range(63), px, py);
        end
        done++;
      end
    end
  endtask

  // Result side stalls for a long stretch while tests keep coming.
  task automatic test_backpressure;
    set_polygon(6, 40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 400;
    for (int i = 0; i < 10; i++)
      send_beat(pip_pkg::ACT_TEST, 0, $signed(16'($urandom)), $signed(16'($urandom)));
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    wait_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_vertices();
    test_directed_cases();
    test_random_polygons(38, 70, 630);
    test_backpressure();
    test_random_polygons(70, 38, 630);
    test_random_polygons(0, 0, 640);
    settle();
    repeat (100) @(posedge clk);
    $display("covered %0d vertex writes and %0d point tests over %0d cycles",
             writes_sent, tests_sent, cycles);
    $display("results: %0d checked, %0d near an edge, %0d inside, %0d mismatches",
             results_seen, near_seen, inside_seen, mismatches);
    if (mismatches == 0)
      $display("tb_point_in_polygon_with_edge_margin_top: clean");
    else
      $display("tb_point_in_polygon_with_edge_margin_top: errors");
    $finish;
  end

endmodule

[filelist.f]
design/pip_pkg.sv
design/pip_ram.sv
design/pip_edge.sv
design/pip_seq.sv
design/point_in_polygon_with_edge_margin_top.sv
tb/tb_point_in_polygon_with_edge_margin_top.sv
